// ===== hdl/pee_pkg.sv =====
// Shared types, widths and helpers of the particle Euler step pipeline.
package pee_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 16;
  localparam int DT_W    = 17;
  localparam int RAD_W   = 31;
  localparam int MAG_W   = DATA_W + 1;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int DSQ_W   = SQ_W + 2;
  localparam int ROOT_W  = DSQ_W / 2;
  localparam int NUM_W   = MAG_W + RAD_W;
  localparam int QUO_W   = RAD_W;
  localparam int REM_W   = ROOT_W + 1;
  localparam int SAT_W   = DATA_W + 3;
  localparam int RSQ_W   = 2 * RAD_W;
  localparam int ADDR_W  = 5;
  localparam int MIN_DSQ = 49;

  typedef enum logic [2:0] {
    REG_STEP_TIME = 3'd0,
    REG_BOUNDS_EN = 3'd1,
    REG_CENTRE_X  = 3'd2,
    REG_CENTRE_Y  = 3'd3,
    REG_CENTRE_Z  = 3'd4,
    REG_RADIUS    = 3'd5
  } pee_reg_t;

  typedef struct packed {
    logic [DATA_W-1:0] pos_x;
    logic [DATA_W-1:0] pos_y;
    logic [DATA_W-1:0] pos_z;
    logic [DATA_W-1:0] vel_x;
    logic [DATA_W-1:0] vel_y;
    logic [DATA_W-1:0] vel_z;
    logic [DATA_W-1:0] life_left;
    logic              alive_in;
  } pee_in_t;

  typedef struct packed {
    logic [DATA_W-1:0] new_pos_x;
    logic [DATA_W-1:0] new_pos_y;
    logic [DATA_W-1:0] new_pos_z;
    logic [DATA_W-1:0] new_life_left;
    logic              alive_out;
  } pee_out_t;

  // Particle after the Euler move.
  typedef struct packed {
    logic [2:0][DATA_W-1:0] pos;
    logic [DATA_W-1:0]      life;
    logic                   alive;
  } pee_mv_t;

  // Side data carried beside the square root.
  typedef struct packed {
    pee_mv_t               mv;
    logic                  clamp;
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } pee_side_t;

  // Side data carried beside the dividers.
  typedef struct packed {
    pee_mv_t    mv;
    logic       clamp;
    logic [2:0] neg;
  } pee_dside_t;

  // Saturate a sign-extended value to the data width.
  function automatic logic [DATA_W-1:0] sat_data(input logic [SAT_W-1:0] v);
    if ((&v[SAT_W-1:DATA_W-1]) || (~|v[SAT_W-1:DATA_W-1])) begin
      return v[DATA_W-1:0];
    end else if (v[SAT_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/pee_move.sv =====
// Euler move: velocity times time step, position and life update.
module pee_move import pee_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  pee_in_t             in_item,
  input  logic [DT_W-1:0]     step_time,
  output logic                mv_vld,
  output pee_mv_t             mv
);

  localparam int PROD_W = DATA_W + DT_W + 1;

  logic                     vld1_r, vld2_r;
  logic                     go1_r;
  logic [2:0][DATA_W-1:0]   pos1_r;
  logic signed [PROD_W-1:0] prod1_r [3];
  logic [DATA_W-1:0]        life1_r;
  pee_mv_t                  mv2_r;

  logic                     go_c;
  logic [2:0][DATA_W-1:0]   vel_c;
  logic signed [PROD_W-1:0] prod_c [3];
  logic [DATA_W-1:0]        life_c;
  pee_mv_t                  mv_nxt;

  always_comb begin
    vel_c = {in_item.vel_z, in_item.vel_y, in_item.vel_x};
    go_c  = in_item.alive_in && ($signed(in_item.life_left) > 0);
    for (int k = 0; k < 3; k++) begin
      prod_c[k] = $signed(vel_c[k]) * $signed({1'b0, step_time});
    end
    if (go_c) begin
      life_c = sat_data(SAT_W'($signed(in_item.life_left)) - SAT_W'(step_time));
    end else begin
      life_c = in_item.life_left;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    go1_r   <= go_c;
    pos1_r  <= {in_item.pos_z, in_item.pos_y, in_item.pos_x};
    prod1_r <= prod_c;
    life1_r <= life_c;
  end

  always_comb begin
    logic signed [PROD_W-1:0] dv;
    logic [SAT_W-1:0]         sum;
    mv_nxt.life  = life1_r;
    mv_nxt.alive = go1_r;
    for (int k = 0; k < 3; k++) begin
      dv  = prod1_r[k] >>> FRAC_W;
      sum = SAT_W'($signed(pos1_r[k])) + SAT_W'(dv);
      mv_nxt.pos[k] = go1_r ? sat_data(sum) : pos1_r[k];
    end
  end

  always_ff @(posedge clk) begin
    mv2_r <= mv_nxt;
  end

  assign mv_vld = vld2_r;
  assign mv     = mv2_r;

endmodule

// ===== hdl/pee_dist.sv =====
// Distance from the sphere centre: offsets, squares, sum and clamp decision.
module pee_dist import pee_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   mv_vld,
  input  pee_mv_t                mv,
  input  logic                   bounds_en,
  input  logic [2:0][DATA_W-1:0] centre,
  input  logic [RSQ_W-1:0]       rsq,
  output logic                   sd_vld,
  output pee_side_t              side,
  output logic [DSQ_W-1:0]       dsq
);

  logic                   vld3_r, vld4_r, vld5_r, vld6_r;
  pee_mv_t                mv3_r, mv4_r, mv5_r;
  logic [2:0]             neg3_r, neg4_r, neg5_r;
  logic [2:0][MAG_W-1:0]  mag3_r, mag4_r, mag5_r;
  logic [2:0][SQ_W-1:0]   sq4_r;
  logic [DSQ_W-1:0]       dsq5_r, dsq6_r;
  pee_side_t              side6_r;

  logic [2:0]             neg_c;
  logic [2:0][MAG_W-1:0]  mag_c;
  logic [2:0][SQ_W-1:0]   sq_c;

  always_comb begin
    logic signed [MAG_W:0] d;
    for (int k = 0; k < 3; k++) begin
      d = $signed({mv.pos[k][DATA_W-1], mv.pos[k]})
        - $signed({centre[k][DATA_W-1], centre[k]});
      neg_c[k] = d[MAG_W];
      mag_c[k] = d[MAG_W] ? MAG_W'(-d) : d[MAG_W-1:0];
    end
    for (int k = 0; k < 3; k++) begin
      sq_c[k] = mag3_r[k] * mag3_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
    end else begin
      vld3_r <= mv_vld;
      vld4_r <= vld3_r;
      vld5_r <= vld4_r;
      vld6_r <= vld5_r;
    end
  end

  always_ff @(posedge clk) begin
    mv3_r  <= mv;
    neg3_r <= neg_c;
    mag3_r <= mag_c;

    mv4_r  <= mv3_r;
    neg4_r <= neg3_r;
    mag4_r <= mag3_r;
    sq4_r  <= sq_c;

    mv5_r  <= mv4_r;
    neg5_r <= neg4_r;
    mag5_r <= mag4_r;
    dsq5_r <= DSQ_W'(sq4_r[0]) + DSQ_W'(sq4_r[1]) + DSQ_W'(sq4_r[2]);

    side6_r.mv    <= mv5_r;
    side6_r.neg   <= neg5_r;
    side6_r.mag   <= mag5_r;
    side6_r.clamp <= mv5_r.alive && bounds_en && (dsq5_r > DSQ_W'(rsq))
                     && (dsq5_r >= DSQ_W'(MIN_DSQ));
    dsq6_r        <= dsq5_r;
  end

  assign sd_vld = vld6_r;
  assign side   = side6_r;
  assign dsq    = dsq6_r;

endmodule

// ===== hdl/pee_sqrt.sv =====
// Pipelined floor square root, one result bit per stage.
module pee_sqrt import pee_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sd_vld,
  input  pee_side_t         side,
  input  logic [DSQ_W-1:0]  dsq,
  output logic              rt_vld,
  output pee_side_t         rt_side,
  output logic [ROOT_W-1:0] root
);

  localparam int RW = ROOT_W + 2;

  logic              vld_r  [ROOT_W];
  pee_side_t         side_r [ROOT_W];
  logic [DSQ_W-1:0]  op_r   [ROOT_W];
  logic [RW-1:0]     rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    logic              vld_in;
    pee_side_t         side_in;
    logic [DSQ_W-1:0]  op_in;
    logic [RW-1:0]     rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RW+1:0]     rw;
    logic [RW+1:0]     trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign vld_in  = sd_vld;
      assign side_in = side;
      assign op_in   = dsq;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign side_in = side_r[i-1];
      assign op_in   = op_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
    end

    assign rw    = {rem_in, op_in[DSQ_W-1 -: 2]};
    assign trial = (RW+2)'({root_in, 2'b01});
    assign ge    = rw >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i] <= side_in;
      op_r[i]   <= op_in << 2;
      rem_r[i]  <= ge ? RW'(rw - trial) : rw[RW-1:0];
      root_r[i] <= {root_in[ROOT_W-2:0], ge};
    end
  end

  assign rt_vld  = vld_r[ROOT_W-1];
  assign rt_side = side_r[ROOT_W-1];
  assign root    = root_r[ROOT_W-1];

endmodule

// ===== hdl/pee_div.sv =====
// Three-lane pipelined restoring divider, one quotient bit per stage.
module pee_div import pee_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  dv_vld,
  input  pee_dside_t            dside,
  input  logic [2:0][NUM_W-1:0] num,
  input  logic [ROOT_W-1:0]     den,
  output logic                  q_vld,
  output pee_dside_t            q_side,
  output logic [2:0][QUO_W-1:0] quo
);

  logic                  vld_r  [QUO_W];
  pee_dside_t            side_r [QUO_W];
  logic [ROOT_W-1:0]     den_r  [QUO_W];
  logic [2:0][REM_W-1:0] rem_r  [QUO_W];
  logic [2:0][QUO_W-1:0] low_r  [QUO_W];
  logic [2:0][QUO_W-1:0] quo_r  [QUO_W];

  for (genvar i = 0; i < QUO_W; i++) begin : g_stage
    logic                  vld_in;
    pee_dside_t            side_in;
    logic [ROOT_W-1:0]     den_in;
    logic [2:0][REM_W-1:0] rem_in;
    logic [2:0][QUO_W-1:0] low_in;
    logic [2:0][QUO_W-1:0] quo_in;
    logic [2:0][REM_W-1:0] rem_nxt;
    logic [2:0][QUO_W-1:0] low_nxt;
    logic [2:0][QUO_W-1:0] quo_nxt;

    if (i == 0) begin : g_first
      always_comb begin
        vld_in  = dv_vld;
        side_in = dside;
        den_in  = den;
        quo_in  = '0;
        for (int k = 0; k < 3; k++) begin
          rem_in[k] = REM_W'(num[k][NUM_W-1:QUO_W]);
          low_in[k] = num[k][QUO_W-1:0];
        end
      end
    end else begin : g_next
      assign vld_in  = vld_r[i-1];
      assign side_in = side_r[i-1];
      assign den_in  = den_r[i-1];
      assign rem_in  = rem_r[i-1];
      assign low_in  = low_r[i-1];
      assign quo_in  = quo_r[i-1];
    end

    always_comb begin
      logic [REM_W-1:0] rw;
      logic             ge;
      for (int k = 0; k < 3; k++) begin
        rw         = {rem_in[k][REM_W-2:0], low_in[k][QUO_W-1]};
        ge         = rw >= REM_W'(den_in);
        rem_nxt[k] = ge ? rw - REM_W'(den_in) : rw;
        low_nxt[k] = low_in[k] << 1;
        quo_nxt[k] = {quo_in[k][QUO_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      side_r[i] <= side_in;
      den_r[i]  <= den_in;
      rem_r[i]  <= rem_nxt;
      low_r[i]  <= low_nxt;
      quo_r[i]  <= quo_nxt;
    end
  end

  assign q_vld  = vld_r[QUO_W-1];
  assign q_side = side_r[QUO_W-1];
  assign quo    = quo_r[QUO_W-1];

endmodule

// ===== hdl/particle_euler_step_sphere_clamp.sv =====
// Top level: one explicit Euler step per particle with a bounding-sphere clamp.
// An item passes from start to out_valid through the move, the distance stages,
// the square root (one root bit per stage), the numerator product, the dividers
// (one quotient bit per stage) and the output register.
// Throughput is one item per cycle; busy stays low. Reset (rst_n low, synchronous)
// clears all valid bits and restores the registers to their reset values.
module particle_euler_step_sphere_clamp import pee_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  pee_in_t           in_item,
  output logic              out_valid,
  output pee_out_t          out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // Configuration registers.
  logic [DT_W-1:0]        step_time_r;
  logic                   bounds_en_r;
  logic [2:0][DATA_W-1:0] centre_r;
  logic [RAD_W-1:0]       radius_r;
  logic [RSQ_W-1:0]       rsq_r;

  logic                   cfg_wr;
  logic [2:0]             cfg_idx;

  // Pipeline links.
  logic                   mv_vld;
  pee_mv_t                mv;
  logic                   sd_vld;
  pee_side_t              side;
  logic [DSQ_W-1:0]       dsq;
  logic                   rt_vld;
  pee_side_t              rt_side;
  logic [ROOT_W-1:0]      root;
  logic                   nm_vld_r;
  pee_dside_t             nm_side_r;
  logic [2:0][NUM_W-1:0]  nm_num_r;
  logic [ROOT_W-1:0]      nm_den_r;
  logic                   q_vld;
  pee_dside_t             q_side;
  logic [2:0][QUO_W-1:0]  quo;
  logic                   out_vld_r;
  pee_out_t               out_r;
  pee_out_t               out_nxt;

  // The pipeline never stalls, so an item is taken on every start.
  assign busy   = 1'b0;
  assign pready = 1'b1;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_time_r <= DT_W'(1092);
      bounds_en_r <= 1'b0;
      centre_r    <= '0;
      radius_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_STEP_TIME: step_time_r <= pwdata[DT_W-1:0];
        REG_BOUNDS_EN: bounds_en_r <= pwdata[0];
        REG_CENTRE_X:  centre_r[0] <= pwdata[DATA_W-1:0];
        REG_CENTRE_Y:  centre_r[1] <= pwdata[DATA_W-1:0];
        REG_CENTRE_Z:  centre_r[2] <= pwdata[DATA_W-1:0];
        REG_RADIUS:    radius_r    <= pwdata[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // The squared radius is registered in the cycle after the radius register, well
  // before any item reaches the compare.
  always_ff @(posedge clk) begin
    rsq_r <= radius_r * radius_r;
  end

  always_comb begin
    unique case (cfg_idx)
      REG_STEP_TIME: prdata = 32'(step_time_r);
      REG_BOUNDS_EN: prdata = 32'(bounds_en_r);
      REG_CENTRE_X:  prdata = centre_r[0];
      REG_CENTRE_Y:  prdata = centre_r[1];
      REG_CENTRE_Z:  prdata = centre_r[2];
      REG_RADIUS:    prdata = 32'(radius_r);
      default:       prdata = '0;
    endcase
  end

  // Euler move: an inactive or dying particle keeps its position and life.
  pee_move u_move (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (start),
    .in_item   (in_item),
    .step_time (step_time_r),
    .mv_vld    (mv_vld),
    .mv        (mv)
  );

  // Offsets from the centre, their squares, and whether the particle is
  // strictly outside the sphere and at least 7 LSB from the centre.
  pee_dist u_dist (
    .clk       (clk),
    .rst_n     (rst_n),
    .mv_vld    (mv_vld),
    .mv        (mv),
    .bounds_en (bounds_en_r),
    .centre    (centre_r),
    .rsq       (rsq_r),
    .sd_vld    (sd_vld),
    .side      (side),
    .dsq       (dsq)
  );

  pee_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .sd_vld  (sd_vld),
    .side    (side),
    .dsq     (dsq),
    .rt_vld  (rt_vld),
    .rt_side (rt_side),
    .root    (root)
  );

  // Numerator of the clamp: offset magnitude times radius per axis.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nm_vld_r <= 1'b0;
    end else begin
      nm_vld_r <= rt_vld;
    end
  end

  always_ff @(posedge clk) begin
    nm_side_r.mv    <= rt_side.mv;
    nm_side_r.clamp <= rt_side.clamp;
    nm_side_r.neg   <= rt_side.neg;
    nm_den_r        <= root;
    for (int k = 0; k < 3; k++) begin
      nm_num_r[k] <= rt_side.mag[k] * radius_r;
    end
  end

  // Since each offset magnitude is at most the root, every quotient fits
  // the radius width.
  pee_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .dv_vld (nm_vld_r),
    .dside  (nm_side_r),
    .num    (nm_num_r),
    .den    (nm_den_r),
    .q_vld  (q_vld),
    .q_side (q_side),
    .quo    (quo)
  );

  // Final stage: the clamped point is centre plus the signed quotient.
  always_comb begin
    logic signed [SAT_W-1:0] cx;
    logic signed [SAT_W-1:0] qx;
    logic [2:0][DATA_W-1:0]  pos;
    for (int k = 0; k < 3; k++) begin
      cx = SAT_W'($signed(centre_r[k]));
      qx = SAT_W'(quo[k]);
      if (q_side.clamp) begin
        pos[k] = sat_data(q_side.neg[k] ? cx - qx : cx + qx);
      end else begin
        pos[k] = q_side.mv.pos[k];
      end
    end
    out_nxt.new_pos_x     = pos[0];
    out_nxt.new_pos_y     = pos[1];
    out_nxt.new_pos_z     = pos[2];
    out_nxt.new_life_left = q_side.mv.life;
    out_nxt.alive_out     = q_side.mv.alive;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= q_vld;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_r;

endmodule
